// ===== src/cfsp_pkg.sv =====
// shared types, constants and the crc-16 byte update for the frame stream parser
// no dependencies; used by the front, queue, back and top modules by scoped names
package cfsp_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 7;
  localparam int CNT_W       = 32;
  localparam int RAM_DEPTH   = 2 * MAX_PAYLOAD;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int OUT_W       = 208;
  localparam int CFG_AW      = 2;

  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PAYLOAD);
  localparam logic [15:0]      CRC_INIT = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY = 16'h1021;

  typedef enum logic [CFG_AW-1:0] {
    CFG_HEAD_FIRST    = 2'd0,
    CFG_HEAD_SECOND   = 2'd1,
    CFG_PAYLOAD_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [8:0] {
    PH_HEAD0 = 9'b000000001,
    PH_HEAD1 = 9'b000000010,
    PH_TYPE  = 9'b000000100,
    PH_LEN   = 9'b000001000,
    PH_SEQLO = 9'b000010000,
    PH_SEQHI = 9'b000100000,
    PH_DATA  = 9'b001000000,
    PH_CRCLO = 9'b010000000,
    PH_CRCHI = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] rx;
    logic [CNT_W-1:0] sync_loss;
    logic [CNT_W-1:0] len_err;
    logic [CNT_W-1:0] crc_err;
    logic [CNT_W-1:0] good;
  } counters_t;

  // one accepted frame waiting to be drained
  typedef struct packed {
    logic [7:0]       frame_type;
    logic [15:0]      sequence_num;
    logic [LEN_W-1:0] length;
    logic             bank;
    counters_t        counts;
  } desc_t;

  typedef struct packed {
    logic      push;
    desc_t     desc;
  } push_t;

  typedef struct packed {
    logic      valid;
    logic      full;
    desc_t     head;
  } queue_status_t;

  typedef struct packed {
    logic [7:0]       frame_type;
    logic [15:0]      sequence_num;
    logic [LEN_W-1:0] length;
    logic [IDX_W-1:0] index;
    logic [7:0]       data;
    logic             last;
    counters_t        counts;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== src/cfsp_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module cfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/cfsp_front.sv =====
// front end: config registers, header search, crc check, counters, payload writes
// depends on cfsp_pkg
module cfsp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [cfsp_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [7:0]                cfg_wdata,
  input  logic                      in_accept,
  input  logic [7:0]                rx_byte,
  output logic                      ram_wr_en,
  output logic [cfsp_pkg::RAM_AW-1:0] ram_wr_addr,
  output logic [7:0]                ram_wr_data,
  output cfsp_pkg::push_t           push_o
);

  logic [7:0]                 head_first_r, head_second_r;
  logic [cfsp_pkg::LEN_W-1:0] limit_r;

  cfsp_pkg::phase_t           phase_r, phase_nxt;
  logic [7:0]                 type_r, type_nxt;
  logic [cfsp_pkg::LEN_W-1:0] length_r, length_nxt;
  logic [15:0]                seq_r, seq_nxt;
  logic [cfsp_pkg::LEN_W-1:0] fill_r, fill_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic [7:0]                 crclo_r, crclo_nxt;
  logic                       bank_r, bank_nxt;
  cfsp_pkg::counters_t        cnt_r, cnt_nxt;

  logic [cfsp_pkg::LEN_W-1:0] lim;
  logic [cfsp_pkg::LEN_W-1:0] fill_inc;
  logic                       drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_first_r  <= 8'd170;
      head_second_r <= 8'd85;
      limit_r       <= cfsp_pkg::MAX_LEN;
    end else if (cfg_wr_en) begin
      unique case (cfsp_pkg::cfg_idx_t'(cfg_addr))
        cfsp_pkg::CFG_HEAD_FIRST:    head_first_r  <= cfg_wdata;
        cfsp_pkg::CFG_HEAD_SECOND:   head_second_r <= cfg_wdata;
        cfsp_pkg::CFG_PAYLOAD_LIMIT: limit_r       <= cfg_wdata[cfsp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // limit saturates at the buffer size
  assign lim      = (limit_r > cfsp_pkg::MAX_LEN) ? cfsp_pkg::MAX_LEN : limit_r;
  assign fill_inc = fill_r + cfsp_pkg::LEN_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    seq_nxt    = seq_r;
    fill_nxt   = fill_r;
    crc_nxt    = crc_r;
    crclo_nxt  = crclo_r;
    bank_nxt   = bank_r;
    cnt_nxt    = cnt_r;
    drop       = 1'b0;
    ram_wr_en  = 1'b0;
    push_o     = '0;
    if (in_accept) begin
      cnt_nxt.rx = cnt_r.rx + cfsp_pkg::CNT_W'(1);
      unique case (phase_r)
        cfsp_pkg::PH_HEAD1: begin
          if (rx_byte == head_second_r) begin
            phase_nxt = cfsp_pkg::PH_TYPE;
            crc_nxt   = cfsp_pkg::CRC_INIT;
          end else begin
            cnt_nxt.sync_loss = cnt_r.sync_loss + cfsp_pkg::CNT_W'(1);
            phase_nxt = (rx_byte == head_first_r) ? cfsp_pkg::PH_HEAD1 : cfsp_pkg::PH_HEAD0;
          end
        end
        cfsp_pkg::PH_TYPE: begin
          type_nxt  = rx_byte;
          crc_nxt   = cfsp_pkg::crc_feed(crc_r, rx_byte);
          phase_nxt = cfsp_pkg::PH_LEN;
        end
        cfsp_pkg::PH_LEN: begin
          if (rx_byte > {1'b0, lim}) begin
            cnt_nxt.len_err = cnt_r.len_err + cfsp_pkg::CNT_W'(1);
            drop = 1'b1;
          end else begin
            length_nxt = rx_byte[cfsp_pkg::LEN_W-1:0];
            fill_nxt   = '0;
            crc_nxt    = cfsp_pkg::crc_feed(crc_r, rx_byte);
            phase_nxt  = cfsp_pkg::PH_SEQLO;
          end
        end
        cfsp_pkg::PH_SEQLO: begin
          seq_nxt   = {8'h00, rx_byte};
          crc_nxt   = cfsp_pkg::crc_feed(crc_r, rx_byte);
          phase_nxt = cfsp_pkg::PH_SEQHI;
        end
        cfsp_pkg::PH_SEQHI: begin
          seq_nxt   = {rx_byte, seq_r[7:0]};
          crc_nxt   = cfsp_pkg::crc_feed(crc_r, rx_byte);
          phase_nxt = (length_r == '0) ? cfsp_pkg::PH_CRCLO : cfsp_pkg::PH_DATA;
        end
        cfsp_pkg::PH_DATA: begin
          ram_wr_en = 1'b1;
          fill_nxt  = fill_inc;
          crc_nxt   = cfsp_pkg::crc_feed(crc_r, rx_byte);
          if (fill_inc >= length_r) begin
            phase_nxt = cfsp_pkg::PH_CRCLO;
          end
        end
        cfsp_pkg::PH_CRCLO: begin
          crclo_nxt = rx_byte;
          phase_nxt = cfsp_pkg::PH_CRCHI;
        end
        cfsp_pkg::PH_CRCHI: begin
          if ({rx_byte, crclo_r} != crc_r) begin
            cnt_nxt.crc_err = cnt_r.crc_err + cfsp_pkg::CNT_W'(1);
          end else begin
            cnt_nxt.good = cnt_r.good + cfsp_pkg::CNT_W'(1);
            push_o.push  = 1'b1;
            bank_nxt     = ~bank_r;
          end
          drop = 1'b1;
        end
        default: begin
          phase_nxt = (rx_byte == head_first_r) ? cfsp_pkg::PH_HEAD1 : cfsp_pkg::PH_HEAD0;
        end
      endcase
    end
    if (drop) begin
      phase_nxt  = cfsp_pkg::PH_HEAD0;
      type_nxt   = '0;
      length_nxt = '0;
      seq_nxt    = '0;
      fill_nxt   = '0;
      crc_nxt    = cfsp_pkg::CRC_INIT;
      crclo_nxt  = '0;
    end
    push_o.desc.frame_type   = type_r;
    push_o.desc.sequence_num = seq_r;
    push_o.desc.length       = length_r;
    push_o.desc.bank         = bank_r;
    push_o.desc.counts       = cnt_nxt;
  end

  assign ram_wr_addr = {bank_r, fill_r[cfsp_pkg::IDX_W-1:0]};
  assign ram_wr_data = rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= cfsp_pkg::PH_HEAD0;
      type_r   <= '0;
      length_r <= '0;
      seq_r    <= '0;
      fill_r   <= '0;
      crc_r    <= cfsp_pkg::CRC_INIT;
      crclo_r  <= '0;
      bank_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      length_r <= length_nxt;
      seq_r    <= seq_nxt;
      fill_r   <= fill_nxt;
      crc_r    <= crc_nxt;
      crclo_r  <= crclo_nxt;
      bank_r   <= bank_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/cfsp_queue.sv =====
// two-entry queue of accepted frame descriptors between front and back
// depends on cfsp_pkg
module cfsp_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfsp_pkg::push_t         push_i,
  input  logic                    pop,
  output cfsp_pkg::queue_status_t status_o
);

  cfsp_pkg::desc_t entry_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push_i.push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_i.push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      entry_r[wr_ptr_r] <= push_i.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign status_o.valid = (count_r != 2'd0);
  assign status_o.full  = (count_r == 2'd2);
  assign status_o.head  = entry_r[rd_ptr_r];

endmodule

// ===== src/cfsp_back.sv =====
// back end: drains queued frames from the payload ram into the output register
// depends on cfsp_pkg
module cfsp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfsp_pkg::queue_status_t     q_status,
  output logic                        q_pop,
  output logic                        ram_rd_en,
  output logic [cfsp_pkg::RAM_AW-1:0] ram_rd_addr,
  input  logic [7:0]                  ram_rd_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cfsp_pkg::result_t           result_o
);

  logic [cfsp_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       valid_r, valid_nxt;
  logic                       issue, item_last, empty;

  logic [7:0]                 type_r;
  logic [15:0]                seq_r;
  logic [cfsp_pkg::LEN_W-1:0] len_r;
  logic [cfsp_pkg::IDX_W-1:0] oidx_r;
  logic                       empty_r, last_r;
  cfsp_pkg::counters_t        cnt_r;

  // ram read data sits in the ram output register, the rest alongside it
  assign issue     = q_status.valid && (!valid_r || out_ready);
  assign empty     = (q_status.head.length == '0);
  assign item_last = empty ||
                     ((cfsp_pkg::LEN_W'(idx_r) + cfsp_pkg::LEN_W'(1)) == q_status.head.length);

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (issue) begin
      valid_nxt = 1'b1;
      idx_nxt   = item_last ? '0 : idx_r + cfsp_pkg::IDX_W'(1);
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  assign q_pop       = issue && item_last;
  assign ram_rd_en   = issue;
  assign ram_rd_addr = {q_status.head.bank, idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      type_r  <= q_status.head.frame_type;
      seq_r   <= q_status.head.sequence_num;
      len_r   <= q_status.head.length;
      oidx_r  <= idx_r;
      empty_r <= empty;
      last_r  <= item_last;
      cnt_r   <= q_status.head.counts;
    end
  end

  assign out_valid             = valid_r;
  assign result_o.frame_type   = type_r;
  assign result_o.sequence_num = seq_r;
  assign result_o.length       = len_r;
  assign result_o.index        = oidx_r;
  assign result_o.data         = empty_r ? 8'h00 : ram_rd_data;
  assign result_o.last         = last_r;
  assign result_o.counts       = cnt_r;

endmodule

// ===== src/crc_frame_stream_parser_unit.sv =====
// top level of the crc frame stream parser: front parser, descriptor queue, back drain
// depends on cfsp_pkg, cfsp_ram, cfsp_front, cfsp_queue, cfsp_back
//
// usage:
//   in_*   : one received byte per request (in_tdata = rx_byte)
//   out_*  : one request per payload byte of a frame that passed its crc-16 check,
//            or a single request with payload_length zero for an empty payload;
//            out_tlast marks the final request of each frame
//   cfg_*  : register writes (0 head_first, 1 head_second, 2 payload_limit), taken
//            at any edge with cfg_wr_en high; the user must write them only while the
//            block is idle; the block itself does not enforce this
// output: via the queue and back end registers, one request per cycle while out_tready
// throughput: one byte per cycle while in_tready; the front parser does its crc update
//   in the cycle a byte arrives and writes payload bytes into one of two ram banks
// stalls: a stalled receiver holds out_* steady; frames queue up to two deep (one per
//   ram bank) and in_tready drops only while both are waiting to drain
// reset: rst_n low at a clock edge returns registers to defaults, clears counters,
//   empties the queue and restarts the header search; no memory clearing pass
module crc_frame_stream_parser_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_wr_en,
  input  logic [cfsp_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [7:0]                  cfg_wdata,
  // received byte stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] rx_byte
  // frame output stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] frame_type, [23:8] frame_sequence, [30:24] payload_length,
  // [36:31] byte_index, [44:37] payload_byte, [76:45] rx_byte_count,
  // [108:77] sync_loss_count, [140:109] length_error_count,
  // [172:141] crc_error_count, [204:173] good_frame_count, [207:205] zero
  output logic [cfsp_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tlast
);

  logic                        in_accept;
  logic                        ram_wr_en, ram_rd_en;
  logic [cfsp_pkg::RAM_AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]                  ram_wr_data, ram_rd_data;
  cfsp_pkg::push_t             push;
  cfsp_pkg::queue_status_t     q_status;
  logic                        q_pop;
  cfsp_pkg::result_t           result;

  // the front only stalls when both ram banks hold frames waiting to drain
  assign in_tready = !q_status.full;
  assign in_accept = in_tvalid && in_tready;

  cfsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_accept   (in_accept),
    .rx_byte     (in_tdata),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .push_o      (push)
  );

  // payload buffer: two banks of one maximum payload each
  cfsp_ram #(
    .WIDTH (8),
    .DEPTH (cfsp_pkg::RAM_DEPTH)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  cfsp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .pop      (q_pop),
    .status_o (q_status)
  );

  cfsp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_status    (q_status),
    .q_pop       (q_pop),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .result_o    (result)
  );

  // pack result fields, first field in the lowest bits
  assign out_tdata = {3'b000,
                      result.counts.good,
                      result.counts.crc_err,
                      result.counts.len_err,
                      result.counts.sync_loss,
                      result.counts.rx,
                      result.data,
                      result.index,
                      result.length,
                      result.sequence_num,
                      result.frame_type};
  assign out_tlast = result.last;

endmodule
